// ----- hdl/conv3x3_clamp_stream_top_defines.svh -----
// ----------------------------------------------------------------------------
// conv3x3_clamp_stream_top_defines
// Assertion macros used by the line window module of the convolution block.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_CLAMP_STREAM_TOP_DEFINES_SVH
`define CONV3X3_CLAMP_STREAM_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define C3C_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c3c assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define C3C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c3c assertion failed");

`endif

// ----- hdl/c3c_pkg.sv -----
// ----------------------------------------------------------------------------
// c3c_pkg
// Types, constants and helpers of the streaming 3x3 convolution block.
// ----------------------------------------------------------------------------
package c3c_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COEF_BITS   = 8;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WIDTH_CAP   = (MAX_WIDTH < STORE_DEPTH) ? MAX_WIDTH : STORE_DEPTH;
  localparam int HEIGHT_CAP  = 1024;
  localparam int MIN_SIZE    = 3;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;
  localparam int KROW_W  = 24;
  localparam int IDX_W   = 3;
  localparam int TAPS    = 9;

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int RSUM_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic signed [ACC_W-1:0] ACC_PIX_MAX = ACC_W'(255);

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;

  // index row*3 + col, col 0 leftmost
  typedef pix_t [TAPS-1:0] win_t;

  typedef struct packed {
    logic [COORD_W-1:0] width_last;
    logic [COORD_W-1:0] height_last;
    coef_t [TAPS-1:0]   coef;
  } cfg_t;

  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               last;
  } tap_t;

  // coefficient pos of a packed kernel row; bits past the row read as zero
  function automatic coef_t coef_at(input logic [KROW_W-1:0] row, input int unsigned pos);
    logic [KROW_W+3*COEF_BITS-1:0] ext;
    ext = {{(3*COEF_BITS){1'b0}}, row};
    return coef_t'(ext[pos*COEF_BITS +: COEF_BITS]);
  endfunction

endpackage

// ----- hdl/c3c_pix_if.sv -----
// ----------------------------------------------------------------------------
// c3c_pix_if
// Pixel input channel: valid/ready with one pixel per item.
// ----------------------------------------------------------------------------
interface c3c_pix_if;
  logic                    valid;
  logic                    ready;
  logic [c3c_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- hdl/c3c_res_if.sv -----
// ----------------------------------------------------------------------------
// c3c_res_if
// Result channel: valid/ready with clamped pixel, centre coordinates, frame end.
// ----------------------------------------------------------------------------
interface c3c_res_if;
  logic                        valid;
  logic                        ready;
  logic [c3c_pkg::PIX_W-1:0]   result_pixel;
  logic [c3c_pkg::COORD_W-1:0] centre_x;
  logic [c3c_pkg::COORD_W-1:0] centre_y;
  logic                        frame_last;

  modport source (output valid, output result_pixel, output centre_x, output centre_y,
                  output frame_last, input ready);
  modport sink   (input valid, input result_pixel, input centre_x, input centre_y,
                  input frame_last, output ready);
endinterface

// ----- hdl/c3c_cfg_if.sv -----
// ----------------------------------------------------------------------------
// c3c_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface c3c_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [c3c_pkg::IDX_W-1:0]  reg_index;
  logic [c3c_pkg::KROW_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hdl/c3c_ram.sv -----
// ----------------------------------------------------------------------------
// c3c_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module c3c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/c3c_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// c3c_cfg_regs
// Configuration registers; frame size limits and coefficient unpacking.
// ----------------------------------------------------------------------------
module c3c_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  c3c_cfg_if.sink           cfg_ch,
  output c3c_pkg::cfg_t     cfg
);

  logic [c3c_pkg::CFG_W-1:0]  width_r;
  logic [c3c_pkg::CFG_W-1:0]  height_r;
  logic [c3c_pkg::KROW_W-1:0] krow_r [3];
  logic [c3c_pkg::CFG_W-1:0]  width_sat;
  logic [c3c_pkg::CFG_W-1:0]  height_sat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= c3c_pkg::CFG_W'(1024);
      height_r  <= c3c_pkg::CFG_W'(1024);
      krow_r[0] <= c3c_pkg::KROW_W'(65280);
      krow_r[1] <= c3c_pkg::KROW_W'(16712959);
      krow_r[2] <= c3c_pkg::KROW_W'(65280);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        c3c_pkg::REG_WIDTH:  width_r   <= cfg_ch.wr_data[c3c_pkg::CFG_W-1:0];
        c3c_pkg::REG_HEIGHT: height_r  <= cfg_ch.wr_data[c3c_pkg::CFG_W-1:0];
        c3c_pkg::REG_KTOP:   krow_r[0] <= cfg_ch.wr_data;
        c3c_pkg::REG_KMID:   krow_r[1] <= cfg_ch.wr_data;
        c3c_pkg::REG_KBOT:   krow_r[2] <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < c3c_pkg::CFG_W'(c3c_pkg::MIN_SIZE)) begin
      width_sat = c3c_pkg::CFG_W'(c3c_pkg::MIN_SIZE);
    end else if (width_r > c3c_pkg::CFG_W'(c3c_pkg::WIDTH_CAP)) begin
      width_sat = c3c_pkg::CFG_W'(c3c_pkg::WIDTH_CAP);
    end else begin
      width_sat = width_r;
    end
    if (height_r < c3c_pkg::CFG_W'(c3c_pkg::MIN_SIZE)) begin
      height_sat = c3c_pkg::CFG_W'(c3c_pkg::MIN_SIZE);
    end else if (height_r > c3c_pkg::CFG_W'(c3c_pkg::HEIGHT_CAP)) begin
      height_sat = c3c_pkg::CFG_W'(c3c_pkg::HEIGHT_CAP);
    end else begin
      height_sat = height_r;
    end
  end

  always_comb begin
    logic [c3c_pkg::CFG_W-1:0] wl;
    logic [c3c_pkg::CFG_W-1:0] hl;
    wl = width_sat - c3c_pkg::CFG_W'(1);
    hl = height_sat - c3c_pkg::CFG_W'(1);
    cfg.width_last  = wl[c3c_pkg::COORD_W-1:0];
    cfg.height_last = hl[c3c_pkg::COORD_W-1:0];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cfg.coef[r*3+c] = c3c_pkg::coef_at(krow_r[r], c);
      end
    end
  end

endmodule

// ----- hdl/c3c_line_window.sv -----
// ----------------------------------------------------------------------------
// c3c_line_window
// Raster counters, line store read-modify-write and the 3x3 pixel window.
// ----------------------------------------------------------------------------
`include "conv3x3_clamp_stream_top_defines.svh"

module c3c_line_window (
  input  logic          clk,
  input  logic          rst_n,
  input  c3c_pkg::cfg_t cfg,
  c3c_pix_if.sink       in_ch,
  output logic          tap_v,
  input  logic          tap_ready,
  output c3c_pkg::tap_t tap
);

  localparam int LS_W = 2 * c3c_pkg::PIX_W;

  // raster position of the next item
  logic [c3c_pkg::COORD_W-1:0] col_r, row_r;
  logic                        row_end, frame_end, in_fire;

  // after-reset clearing pass over the line store
  logic                        clearing_r;
  logic [c3c_pkg::ADDR_W-1:0]  clr_cnt_r;

  // read stage
  logic                        s1_v_r, s1_emit_r, s1_last_r;
  c3c_pkg::pix_t               s1_pix_r;
  logic [c3c_pkg::ADDR_W-1:0]  s1_addr_r;
  logic [c3c_pkg::COORD_W-1:0] s1_cx_r, s1_cy_r;
  logic                        s1_go;

  logic                        ram_we;
  logic [c3c_pkg::ADDR_W-1:0]  ram_waddr;
  logic [LS_W-1:0]             ram_wdata, ram_rdata;
  logic [c3c_pkg::ADDR_W-1:0]  ram_raddr;

  c3c_pkg::win_t               win_r, win_nxt;
  c3c_pkg::pix_t               top_px, mid_px;
  logic                        tap_v_r;
  c3c_pkg::tap_t               tap_r;

  assign row_end   = col_r >= cfg.width_last;
  assign frame_end = row_r >= cfg.height_last;
  assign s1_go     = s1_v_r && (!s1_emit_r || !tap_v_r || tap_ready);
  assign in_ch.ready = !clearing_r && (!s1_v_r || s1_go);
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign ram_raddr = col_r[c3c_pkg::ADDR_W-1:0];
  assign top_px    = ram_rdata[LS_W-1:c3c_pkg::PIX_W];
  assign mid_px    = ram_rdata[c3c_pkg::PIX_W-1:0];

  // upper half: row y-2, lower half: row y-1
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_go;
      ram_waddr = s1_addr_r;
      ram_wdata = {mid_px, s1_pix_r};
    end
  end

  c3c_ram #(
    .WIDTH (LS_W),
    .DEPTH (c3c_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + c3c_pkg::ADDR_W'(1);
      if (clr_cnt_r == c3c_pkg::ADDR_W'(c3c_pkg::STORE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + c3c_pkg::COORD_W'(1);
      end else begin
        col_r <= col_r + c3c_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_ch.pixel_value;
      s1_addr_r <= ram_raddr;
      s1_cx_r   <= col_r - c3c_pkg::COORD_W'(1);
      s1_cy_r   <= row_r - c3c_pkg::COORD_W'(1);
      s1_emit_r <= (col_r >= c3c_pkg::COORD_W'(2)) && (row_r >= c3c_pkg::COORD_W'(2));
      s1_last_r <= row_end && frame_end;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_px;
    win_nxt[5] = mid_px;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_v_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      tap_v_r <= 1'b1;
    end else if (tap_ready) begin
      tap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      tap_r.win  <= win_nxt;
      tap_r.cx   <= s1_cx_r;
      tap_r.cy   <= s1_cy_r;
      tap_r.last <= s1_last_r;
    end
  end

  assign tap_v = tap_v_r;
  assign tap   = tap_r;

  // a pixel's write-back never lands on the entry read in the same cycle
  `C3C_ASSERT_SAME(a_rmw_no_overlap, s1_go && in_fire, ram_waddr != ram_raddr)
  `C3C_ASSERT_NEXT(a_emit_reaches_tap, s1_go && s1_emit_r, tap_v_r)
  `C3C_ASSERT_SAME(a_tap_interior, tap_v_r, (tap_r.cx != '0) && (tap_r.cy != '0))

endmodule

// ----- hdl/c3c_mac.sv -----
// ----------------------------------------------------------------------------
// c3c_mac
// Nine-tap multiply, row sums, total and clamp into the output register.
// ----------------------------------------------------------------------------
module c3c_mac (
  input  logic          clk,
  input  logic          rst_n,
  input  c3c_pkg::cfg_t cfg,
  input  logic          tap_v,
  output logic          tap_ready,
  input  c3c_pkg::tap_t tap,
  c3c_res_if.source     out_ch
);

  logic                        p_v_r, r_v_r, o_v_r;
  logic                        p_free, r_free, o_free;
  c3c_pkg::prod_t              p_prod_r [c3c_pkg::TAPS];
  c3c_pkg::rsum_t              r_sum_r [3];
  logic [c3c_pkg::COORD_W-1:0] p_cx_r, p_cy_r, r_cx_r, r_cy_r;
  logic                        p_last_r, r_last_r;
  logic signed [c3c_pkg::ACC_W-1:0] total;
  c3c_pkg::pix_t               clamped;

  assign o_free    = !o_v_r || out_ch.ready;
  assign r_free    = !r_v_r || o_free;
  assign p_free    = !p_v_r || r_free;
  assign tap_ready = p_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      r_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_free) p_v_r <= tap_v;
      if (r_free) r_v_r <= p_v_r;
      if (o_free) o_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && tap_v) begin
      for (int i = 0; i < c3c_pkg::TAPS; i++) begin
        p_prod_r[i] <= c3c_pkg::prod_t'($signed(cfg.coef[i]))
                     * c3c_pkg::prod_t'($signed({1'b0, tap.win[i]}));
      end
      p_cx_r   <= tap.cx;
      p_cy_r   <= tap.cy;
      p_last_r <= tap.last;
    end
  end

  always_ff @(posedge clk) begin
    if (r_free && p_v_r) begin
      for (int r = 0; r < 3; r++) begin
        r_sum_r[r] <= c3c_pkg::RSUM_W'(p_prod_r[r*3]) + c3c_pkg::RSUM_W'(p_prod_r[r*3+1])
                    + c3c_pkg::RSUM_W'(p_prod_r[r*3+2]);
      end
      r_cx_r   <= p_cx_r;
      r_cy_r   <= p_cy_r;
      r_last_r <= p_last_r;
    end
  end

  always_comb begin
    total = c3c_pkg::ACC_W'(r_sum_r[0]) + c3c_pkg::ACC_W'(r_sum_r[1])
          + c3c_pkg::ACC_W'(r_sum_r[2]);
    if (total < 0) begin
      clamped = '0;
    end else if (total > c3c_pkg::ACC_PIX_MAX) begin
      clamped = '1;
    end else begin
      clamped = total[c3c_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && r_v_r) begin
      out_ch.result_pixel <= clamped;
      out_ch.centre_x     <= r_cx_r;
      out_ch.centre_y     <= r_cy_r;
      out_ch.frame_last   <= r_last_r;
    end
  end

  assign out_ch.valid = o_v_r;

endmodule

// ----- hdl/conv3x3_clamp_stream_top.sv -----
// ----------------------------------------------------------------------------
// conv3x3_clamp_stream_top
// Streaming 3x3 convolution with clamp over an 8-bit raster image.
//
// Pixels enter on in_ch in raster order, one item per pixel, valid/ready.
// For every pixel at column >= 2 and row >= 2 one result leaves on out_ch:
// the signed-coefficient sum over the 3x3 neighbourhood clamped to 0..255,
// for the centre one row up and one column left, with its coordinates and
// a flag on the last interior result of the frame. Border pixels give none.
// cfg_ch writes width, height and the three packed kernel rows; it is always
// ready, and the user must write it only while the block is idle; the block
// itself does not enforce this. Throughput is one pixel per cycle while out_ch
// does not stall, with a single line store that is read at a pixel's accept
// and written back as the pixel leaves the read stage. After reset the line
// store is zeroed in a pass over all 1024 entries; in_ch.ready stays low
// during it. When out_ch stalls, the pipeline keeps taking pixels until its
// four internal stages and the output register are full.
// ----------------------------------------------------------------------------
module conv3x3_clamp_stream_top (
  input  logic       clk,
  input  logic       rst_n,
  c3c_pix_if.sink    in_ch,
  c3c_res_if.source  out_ch,
  c3c_cfg_if.sink    cfg_ch
);

  c3c_pkg::cfg_t cfg;
  c3c_pkg::tap_t tap;
  logic          tap_v;
  logic          tap_ready;

  c3c_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  c3c_line_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .tap_v     (tap_v),
    .tap_ready (tap_ready),
    .tap       (tap)
  );

  c3c_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .tap_v     (tap_v),
    .tap_ready (tap_ready),
    .tap       (tap),
    .out_ch    (out_ch)
  );

endmodule

// ----- dv/c3c_conv_shadow_pkg.sv -----
// ----------------------------------------------------------------------------
// c3c_conv_shadow_pkg
// Cycle-free shadow of the 3x3 convolution block: keeps its own copy of the
// registers, line stores, window and raster position. It computes the result
// due for each accepted interior pixel and matches the block's results.
// ----------------------------------------------------------------------------
package c3c_conv_shadow_pkg;
  import c3c_pkg::*;

  localparam int PIX_MAX = (1 << PIX_W) - 1;

  typedef struct packed {
    pix_t               value;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               last;
  } conv_out_t;

  class conv3x3_shadow;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [KROW_W-1:0]  krow [3];
    pix_t               upper_line [STORE_DEPTH];
    pix_t               lower_line [STORE_DEPTH];
    pix_t               win [TAPS];
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    conv_out_t          due_results [$];
    int unsigned        mismatches;

    function new();
      width_reg  = CFG_W'(1024);
      height_reg = CFG_W'(1024);
      krow[0] = 24'h00FF00;
      krow[1] = 24'hFF04FF;
      krow[2] = 24'h00FF00;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos    = '0;
      row_pos    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
      case (idx)
        REG_WIDTH:  width_reg  = data[CFG_W-1:0];
        REG_HEIGHT: height_reg = data[CFG_W-1:0];
        REG_KTOP:   krow[0]    = data;
        REG_KMID:   krow[1]    = data;
        REG_KBOT:   krow[2]    = data;
        default: ;
      endcase
    endfunction

    function int unsigned width_in_use();
      int unsigned w;
      w = width_reg;
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      return w;
    endfunction

    function int unsigned height_in_use();
      int unsigned h;
      h = height_reg;
      if (h < MIN_SIZE) h = MIN_SIZE;
      if (h > HEIGHT_CAP) h = HEIGHT_CAP;
      return h;
    endfunction

    // bits shifted in past the 24-bit row are zero
    function coef_t tap_coef(input int unsigned r, input int unsigned c);
      return coef_t'(krow[r] >> (c * COEF_BITS));
    endfunction

    function void take_pixel(input pix_t px);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      pix_t        above2;
      pix_t        above1;
      bit          row_end;
      bit          frame_end;
      int          acc;
      conv_out_t   res;
      w         = width_in_use();
      h         = height_in_use();
      slot      = col_pos % STORE_DEPTH;
      above2    = upper_line[slot];
      above1    = lower_line[slot];
      row_end   = col_pos >= w - 1;
      frame_end = row_pos >= h - 1;
      upper_line[slot] = above1;
      lower_line[slot] = px;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = px;
      if (col_pos >= 2 && row_pos >= 2) begin
        acc = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            acc += int'(tap_coef(r, c)) * int'(win[r*3+c]);
        if (acc < 0) acc = 0;
        if (acc > PIX_MAX) acc = PIX_MAX;
        res.value = acc[PIX_W-1:0];
        res.cx    = col_pos - 1'b1;
        res.cy    = row_pos - 1'b1;
        res.last  = row_end && frame_end;
        due_results.push_back(res);
      end
      if (row_end) begin
        col_pos = '0;
        row_pos = frame_end ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    function void match_result(input conv_out_t got);
      conv_out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none pending: value=%0d x=%0d y=%0d last=%0d",
                 $time, got.value, got.cx, got.cy, got.last);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected value=%0d x=%0d y=%0d last=%0d",
                 $time, want.value, want.cx, want.cy, want.last);
        $display("%0t:                  actual   value=%0d x=%0d y=%0d last=%0d",
                 $time, got.value, got.cx, got.cy, got.last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the 3x3 convolution block: directed frames on tiny images,
// then random frames, partial frames, mid-frame size changes and one full
// 1024-wide row, with random idle cycles on both channels. Results are
// matched in order against the shadow model.
// ----------------------------------------------------------------------------
module tb_top;
  import c3c_pkg::*;
  import c3c_conv_shadow_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int SMALL_ITEMS   = 1900;

  logic clk;
  logic rst_n;
  bit   steady_flow = 1'b0;

  c3c_pix_if pix_ch ();
  c3c_res_if res_ch ();
  c3c_cfg_if cfg_bus ();

  conv3x3_shadow shadow = new();

  conv3x3_clamp_stream_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL conv3x3_clamp_stream_top");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready)
        shadow.write_reg(cfg_bus.reg_index, cfg_bus.wr_data);
      if (pix_ch.valid && pix_ch.ready)
        shadow.take_pixel(pix_ch.pixel_value);
      if (res_ch.valid && res_ch.ready)
        shadow.match_result({res_ch.result_pixel, res_ch.centre_x, res_ch.centre_y,
                             res_ch.frame_last});
    end
  end

  initial begin : result_sink
    res_ch.ready = 1'b0;
    forever @(negedge clk) res_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
  end

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [KROW_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk) cfg_bus.valid <= 1'b0;
  endtask

  task automatic push_pixel(input pix_t px);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < 10) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= px;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk) pix_ch.valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
  endtask

  // border pixels still in flight leave no result behind, so wait them out
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size register value with random junk above the 11 used bits
  function automatic logic [KROW_W-1:0] size_pick();
    int unsigned s;
    case ($urandom_range(0, 9))
      0:       s = $urandom_range(0, 2);
      1:       s = $urandom_range(1025, 2047);
      2:       s = 1024;
      default: s = $urandom_range(3, 9);
    endcase
    return {13'($urandom), CFG_W'(s)};
  endfunction

  function automatic logic [KROW_W-1:0] kernel_row_pick();
    case ($urandom_range(0, 7))
      0:       return 24'h7F7F7F;
      1:       return 24'h808080;
      2:       return 24'h000000;
      3:       return 24'h00FF00;
      default: return KROW_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned fill;
    int unsigned phase_no;
    int unsigned small_items;
    bit          wide_done;
    pix_t        px;

    rst_n               = 1'b0;
    pix_ch.valid        = 1'b0;
    pix_ch.pixel_value  = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = '0;
    cfg_bus.wr_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset kernels on a 3x4 image; width write masks to zero and saturates up
    set_reg(REG_WIDTH, 24'hFFF800);
    set_reg(REG_HEIGHT, 24'd4);
    for (int k = 0; k < 9; k++) push_pixel((k % 2) ? pix_t'(0) : pix_t'(PIX_MAX));
    quiesce();
    // last row of that frame with the largest positive kernel
    set_reg(REG_KTOP, 24'h7F7F7F);
    set_reg(REG_KMID, 24'h7F7F7F);
    set_reg(REG_KBOT, 24'h7F7F7F);
    for (int k = 0; k < 3; k++) push_pixel(pix_t'(PIX_MAX));
    quiesce();
    // identity kernel on a 3x3 frame, plus a write to an unmapped index
    set_reg(REG_WIDTH, 24'd3);
    set_reg(REG_HEIGHT, 24'd3);
    set_reg(REG_KTOP, 24'h000000);
    set_reg(REG_KMID, 24'h000100);
    set_reg(REG_KBOT, 24'h000000);
    set_reg(IDX_W'(int'(REG_KBOT) + $urandom_range(1, 3)), KROW_W'($urandom));
    for (int k = 0; k < 9; k++) push_pixel(pix_t'($urandom));
    quiesce();
    // oversize registers saturate; row left open for the next width
    set_reg(REG_WIDTH, 24'h0007FF);
    set_reg(REG_HEIGHT, 24'h0007FF);
    for (int k = 0; k < 3; k++) push_pixel(pix_t'($urandom));

    phase_no    = 0;
    small_items = 0;
    wide_done   = 1'b0;
    while (small_items < SMALL_ITEMS) begin
      phase_no++;
      quiesce();
      steady_flow = (phase_no >= 2 && phase_no < 10);

      if (!wide_done && small_items >= SMALL_ITEMS / 2) begin
        wide_done = 1'b1;
        set_reg(REG_WIDTH, 24'd3);
        set_reg(REG_HEIGHT, 24'd1024);
        // walk to a row start at row two or later, then run one full-width row
        while (!(shadow.col_pos == 0 && shadow.row_pos >= 2)) begin
          push_pixel(pix_t'($urandom));
          @(negedge clk) pix_ch.valid <= 1'b0;
        end
        quiesce();
        set_reg(REG_WIDTH, 24'd1024);
        for (int k = 0; k < WIDTH_CAP; k++) push_pixel(pix_t'($urandom));
        small_items += WIDTH_CAP;
        continue;
      end

      if (phase_no == 1 || $urandom_range(0, 2) != 0) set_reg(REG_WIDTH, size_pick());
      if (phase_no == 1 || $urandom_range(0, 2) != 0) set_reg(REG_HEIGHT, size_pick());
      if (phase_no == 1 || $urandom_range(0, 2) != 0) set_reg(REG_KTOP, kernel_row_pick());
      if (phase_no == 1 || $urandom_range(0, 2) != 0) set_reg(REG_KMID, kernel_row_pick());
      if (phase_no == 1 || $urandom_range(0, 2) != 0) set_reg(REG_KBOT, kernel_row_pick());
      if ($urandom_range(0, 9) == 0)
        set_reg(IDX_W'(int'(REG_KBOT) + $urandom_range(1, 3)), KROW_W'($urandom));

      w = shadow.width_in_use();
      h = shadow.height_in_use();
      if (w * h > 400)
        n = $urandom_range(1, 60);
      else if ($urandom_range(0, 9) < 7)
        n = w * h * $urandom_range(1, 3);
      else
        n = $urandom_range(1, 2 * w * h);

      fill = $urandom_range(0, 9);
      for (int k = 0; k < n; k++) begin
        if (fill == 0)
          px = '0;
        else if (fill == 1)
          px = pix_t'(PIX_MAX);
        else
          px = pix_t'($urandom);
        if (k == n / 2 && phase_no % 9 == 4) drain_results();
        push_pixel(px);
      end
      small_items += n;
    end

    steady_flow = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
      $display("PASS conv3x3_clamp_stream_top");
    end else begin
      $display("FAIL conv3x3_clamp_stream_top");
    end
    $finish;
  end

endmodule
